// ----- design/xorshift64_star_random_source_top_macros.svh -----
// Assertion helpers used by the top-level RTL file
`ifndef XORSHIFT64_STAR_RANDOM_SOURCE_TOP_MACROS_SVH
`define XORSHIFT64_STAR_RANDOM_SOURCE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define XSRS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define XSRS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/xsrs_pkg.sv -----
`default_nettype none
package xsrs_pkg;

	localparam int STATE_W = 64;
	localparam int DRAW_W  = 32;
	localparam int DIGIT_W = 4;

	localparam logic [STATE_W-1:0] GOLDEN_SEED  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [STATE_W-1:0] SCRAMBLE_MUL = 64'd2685821657736338717;

	localparam int SHIFT_A = 12;
	localparam int SHIFT_B = 25;
	localparam int SHIFT_C = 27;

	localparam logic [1:0] OP_RAW     = 2'd0;
	localparam logic [1:0] OP_BOUNDED = 2'd1;
	localparam logic [1:0] OP_FLOAT   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stat_t;

	// constant times one multiplier digit, kept mod 2^64
	function automatic logic [STATE_W-1:0] mul_digit(input logic [DIGIT_W-1:0] d);
		logic [STATE_W-1:0] acc;
		acc = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			if (d[i]) begin
				acc = acc + (SCRAMBLE_MUL << i);
			end
		end
		return acc;
	endfunction

endpackage
`default_nettype wire

// ----- design/xsrs_mul.sv -----
`default_nettype none
module xsrs_mul (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [xsrs_pkg::STATE_W-1:0] x,
	output xsrs_pkg::stat_t                   st,
	output logic      [xsrs_pkg::DRAW_W-1:0]  draw
);

	localparam int NDIG  = xsrs_pkg::STATE_W / xsrs_pkg::DIGIT_W;
	localparam int CNT_W = $clog2(NDIG);

	logic [xsrs_pkg::STATE_W-1:0] x_q;
	logic [xsrs_pkg::STATE_W-1:0] acc_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NDIG - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Horner form, most significant digit first
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			acc_q <= '0;
		end else if (busy_q) begin
			x_q   <= x_q << xsrs_pkg::DIGIT_W;
			acc_q <= (acc_q << xsrs_pkg::DIGIT_W)
				+ xsrs_pkg::mul_digit(x_q[xsrs_pkg::STATE_W-1 -: xsrs_pkg::DIGIT_W]);
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	assign draw    = acc_q[xsrs_pkg::STATE_W-1 -: xsrs_pkg::DRAW_W];

endmodule
`default_nettype wire

// ----- design/xsrs_mod.sv -----
`default_nettype none
module xsrs_mod (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [xsrs_pkg::DRAW_W-1:0] dividend,
	input  wire logic [xsrs_pkg::DRAW_W:0]   divisor,
	output xsrs_pkg::stat_t                  st,
	output logic      [xsrs_pkg::DRAW_W-1:0] rem
);

	localparam int W     = xsrs_pkg::DRAW_W;
	localparam int CNT_W = $clog2(W);

	logic [W:0]       rem_q;
	logic [W-1:0]     dvd_q;
	logic [W:0]       div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W+1:0]     trial;
	logic             ge;
	logic [W:0]       rem_nxt;

	// restoring step: bring down one dividend bit, subtract if it fits
	always_comb begin
		trial   = {rem_q, dvd_q[W-1]};
		ge      = trial >= {1'b0, div_q};
		rem_nxt = ge ? (W+1)'(trial - {1'b0, div_q}) : trial[W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_q << 1;
		end
	end

	assign st.busy = busy_q;
	assign st.done = done_q;
	// remainder stays below a divisor of at most 2^32
	assign rem     = rem_q[W-1:0];

endmodule
`default_nettype wire

// ----- design/xorshift64_star_random_source_top.sv -----
// A raw draw passes through the digit-serial scramble multiply; a bounded value then
// adds the bit-serial modulo, and a float adds the normalize shift, one bit per cycle.
// The block takes one word at a time: the next word is taken once the result is in
// the output register.
// Reset clears generator state to zero (golden constant on first draw).
`default_nettype none
`include "xorshift64_star_random_source_top_macros.svh"
module xorshift64_star_random_source_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [63:0] seed_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // range_low[31:0], range_high[63:32]
	input  wire logic [1:0]  s_tuser,   // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata    // raw_draw[31:0], bounded_value[63:32], float_bits[95:64]
);

	localparam int SW = xsrs_pkg::STATE_W;
	localparam int DW = xsrs_pkg::DRAW_W;

	xsrs_pkg::state_t state_q, state_nxt;

	logic [SW-1:0]        gen_q;
	logic [SW-1:0]        x0, x1, x2, x3;
	logic [1:0]           op_q;
	logic signed [DW-1:0] lo_q, hi_q;
	logic [DW:0]          span_q;
	logic [DW-1:0]        draw_q;
	logic [DW-1:0]        bnd_q;
	logic [DW-1:0]        flt_q;
	logic [DW-1:0]        nrm_q;
	logic [4:0]           nsh_q;
	logic                 out_valid_q;
	logic [95:0]          out_q;

	logic                 accept;
	logic                 load_out;
	logic                 mod_start;
	logic                 nrm_end;
	logic                 rnd;
	logic [24:0]          mant_r;
	logic [7:0]           expo;
	logic [DW-1:0]        fbits;

	xsrs_pkg::stat_t      mul_st, mod_st;
	logic [DW-1:0]        mul_draw;
	logic [DW-1:0]        mod_rem;

	assign s_tready = (state_q == xsrs_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// advance the xorshift state, substituting the golden constant for zero
	always_comb begin
		x0 = (gen_q == '0) ? xsrs_pkg::GOLDEN_SEED : gen_q;
		x1 = x0 ^ (x0 >> xsrs_pkg::SHIFT_A);
		x2 = x1 ^ (x1 << xsrs_pkg::SHIFT_B);
		x3 = x2 ^ (x2 >> xsrs_pkg::SHIFT_C);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (seed_we) begin
			gen_q <= (seed_wdata == '0) ? xsrs_pkg::GOLDEN_SEED : seed_wdata;
		end else if (accept) begin
			gen_q <= x3;
		end
	end

	xsrs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.x      (x3),
		.st     (mul_st),
		.draw   (mul_draw)
	);

	assign mod_start = (state_q == xsrs_pkg::ST_MUL) && mul_st.done
		&& (op_q == xsrs_pkg::OP_BOUNDED);

	xsrs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mul_draw),
		.divisor  (span_q),
		.st       (mod_st),
		.rem      (mod_rem)
	);

	// float from the normalized draw: round to 24 bits, nearest even
	always_comb begin
		nrm_end = (nrm_q == '0) || nrm_q[DW-1];
		rnd     = nrm_q[7] && ((|nrm_q[6:0]) || nrm_q[8]);
		mant_r  = {1'b0, nrm_q[DW-1:8]} + 25'(rnd);
		expo    = 8'(8'd126 - {3'b000, nsh_q} + {7'd0, mant_r[24]});
		fbits   = (nrm_q == '0) ? '0 : {1'b0, expo, mant_r[22:0]};
	end

	always_comb begin
		state_nxt = state_q;
		load_out  = 1'b0;
		case (state_q)
			xsrs_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = xsrs_pkg::ST_MUL;
				end
			end
			xsrs_pkg::ST_MUL: begin
				if (mul_st.done) begin
					if (op_q == xsrs_pkg::OP_BOUNDED || op_q == xsrs_pkg::OP_FLOAT) begin
						state_nxt = xsrs_pkg::ST_FIN;
					end else begin
						state_nxt = xsrs_pkg::ST_DONE;
					end
				end
			end
			xsrs_pkg::ST_FIN: begin
				if (op_q == xsrs_pkg::OP_BOUNDED) begin
					if (mod_st.done) begin
						state_nxt = xsrs_pkg::ST_DONE;
					end
				end else if (nrm_end) begin
					state_nxt = xsrs_pkg::ST_DONE;
				end
			end
			xsrs_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out  = 1'b1;
					state_nxt = xsrs_pkg::ST_IDLE;
				end
			end
			default: state_nxt = xsrs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xsrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			lo_q  <= s_tdata[31:0];
			hi_q  <= s_tdata[63:32];
			bnd_q <= '0;
			flt_q <= '0;
		end
		if (state_q == xsrs_pkg::ST_MUL) begin
			// order the bounds, then register span from the ordered bounds
			if (lo_q > hi_q) begin
				lo_q <= hi_q;
				hi_q <= lo_q;
			end
			span_q <= {hi_q[DW-1], hi_q} - {lo_q[DW-1], lo_q} + (DW+1)'(1);
			if (mul_st.done) begin
				draw_q <= mul_draw;
				nrm_q  <= mul_draw;
				nsh_q  <= '0;
			end
		end
		if (state_q == xsrs_pkg::ST_FIN) begin
			if (op_q == xsrs_pkg::OP_BOUNDED) begin
				if (mod_st.done) begin
					bnd_q <= lo_q + mod_rem;
				end
			end else if (nrm_end) begin
				flt_q <= fbits;
			end else begin
				nrm_q <= nrm_q << 1;
				nsh_q <= nsh_q + 1'b1;
			end
		end
		if (load_out) begin
			out_q <= {flt_q, bnd_q, draw_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	`XSRS_ASSERT_IMP(a_idle_units_quiet, state_q == xsrs_pkg::ST_IDLE,
		!mul_st.busy && !mod_st.busy, "serial unit busy while idle")
	`XSRS_ASSERT_NXT(a_accept_starts_mul, accept,
		state_q == xsrs_pkg::ST_MUL && mul_st.busy, "multiply did not start")
	`XSRS_ASSERT_IMP(a_mod_only_bounded, mod_st.done,
		state_q == xsrs_pkg::ST_FIN && op_q == xsrs_pkg::OP_BOUNDED,
		"modulo finished outside a bounded request")
	`XSRS_ASSERT_NXT(a_hold_when_blocked,
		state_q == xsrs_pkg::ST_DONE && out_valid_q && !m_tready,
		state_q == xsrs_pkg::ST_DONE, "result overwrote an untaken word")

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
module tb;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [31:0] float_bits;
		logic [31:0] bounded_value;
		logic [31:0] raw_draw;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_we = 1'b0;
	logic [63:0] seed_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;

	logic [63:0] gen_state = '0;
	reply_t      pending_replies[$];
	int          failures = 0;
	int          hold_cycles = 0;
	bit          no_gaps = 1'b0;
	bit          offering = 1'b0;

	xorshift64_star_random_source_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_wdata (seed_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] single_of_draw(input logic [31:0] d);
		int          p;
		int          s;
		logic [31:0] m;
		logic [31:0] rem;
		logic [31:0] half;
		logic [31:0] expo;
		if (d == 32'd0) begin
			return 32'd0;
		end
		p = 31;
		while (!d[p]) begin
			p--;
		end
		if (p <= 23) begin
			m = d << (23 - p);
		end else begin
			s = p - 23;
			rem = d & ((32'd1 << s) - 32'd1);
			half = 32'd1 << (s - 1);
			m = d >> s;
			// round to nearest, ties to even
			if (rem > half || (rem == half && m[0])) begin
				m = m + 32'd1;
			end
			if (m == (32'd1 << 24)) begin
				m = m >> 1;
				p++;
			end
		end
		expo = p + 95;
		return (expo << 23) | {9'd0, m[22:0]};
	endfunction

	// advance the generator and build the reply for one request
	function automatic reply_t predict_reply(input logic [1:0] op, input logic [31:0] lo,
			input logic [31:0] hi);
		logic [63:0] x;
		logic [63:0] lo_ext;
		logic [63:0] hi_ext;
		logic [63:0] swap;
		logic [63:0] span;
		logic [63:0] offset;
		logic [31:0] d;
		reply_t      r;
		if (gen_state == '0) begin
			gen_state = xsrs_pkg::GOLDEN_SEED;
		end
		x = gen_state;
		x = x ^ (x >> xsrs_pkg::SHIFT_A);
		x = x ^ (x << xsrs_pkg::SHIFT_B);
		x = x ^ (x >> xsrs_pkg::SHIFT_C);
		gen_state = x;
		x = x * xsrs_pkg::SCRAMBLE_MUL;
		d = x[63:32];
		r = '0;
		r.raw_draw = d;
		case (op)
			xsrs_pkg::OP_BOUNDED: begin
				lo_ext = {{32{lo[31]}}, lo};
				hi_ext = {{32{hi[31]}}, hi};
				if ($signed(lo) > $signed(hi)) begin
					swap = lo_ext;
					lo_ext = hi_ext;
					hi_ext = swap;
				end
				span = hi_ext - lo_ext + 64'd1;
				offset = {32'd0, d} % span;
				r.bounded_value = lo_ext[31:0] + offset[31:0];
			end
			xsrs_pkg::OP_FLOAT: begin
				r.float_bits = single_of_draw(d);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// seed whose first draw is the given value
	function automatic logic [63:0] seed_giving_draw(input logic [31:0] draw);
		logic [63:0] inv;
		logic [63:0] x;
		inv = xsrs_pkg::SCRAMBLE_MUL;
		for (int i = 0; i < 5; i++) begin
			inv = inv * (64'd2 - xsrs_pkg::SCRAMBLE_MUL * inv);
		end
		x = {draw, 32'h5A5A_0001} * inv;
		x = x ^ (x >> xsrs_pkg::SHIFT_C) ^ (x >> (2 * xsrs_pkg::SHIFT_C));
		x = x ^ (x << xsrs_pkg::SHIFT_B) ^ (x << (2 * xsrs_pkg::SHIFT_B));
		x = x ^ (x >> xsrs_pkg::SHIFT_A) ^ (x >> (2 * xsrs_pkg::SHIFT_A))
			^ (x >> (3 * xsrs_pkg::SHIFT_A)) ^ (x >> (4 * xsrs_pkg::SHIFT_A))
			^ (x >> (5 * xsrs_pkg::SHIFT_A));
		return x;
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [31:0] lo,
			input logic [31:0] hi);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		offering = 1'b1;
		s_tdata <= {hi, lo};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(predict_reply(op, lo, hi));
		@(negedge clk);
	endtask

	task automatic drain_replies();
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_replies.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic load_seed(input logic [63:0] value);
		drain_replies();
		seed_we <= 1'b1;
		seed_wdata <= value;
		@(negedge clk);
		seed_we <= 1'b0;
		gen_state = (value == '0) ? xsrs_pkg::GOLDEN_SEED : value;
		@(negedge clk);
	endtask

	task automatic test_reset_state();
		// no seed written: the first draw starts from the golden constant
		send_request(xsrs_pkg::OP_RAW, 32'd0, 32'd0);
		send_request(xsrs_pkg::OP_BOUNDED, 32'd0, 32'd100);
		send_request(xsrs_pkg::OP_FLOAT, 32'd0, 32'd0);
		send_request(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	task automatic test_seed_extremes();
		load_seed(64'd0);
		send_request(xsrs_pkg::OP_RAW, 32'd0, 32'd0);
		load_seed('1);
		send_request(xsrs_pkg::OP_BOUNDED, 32'h8000_0000, 32'h7FFF_FFFF);
		load_seed(64'd1);
		send_request(xsrs_pkg::OP_FLOAT, 32'd0, 32'd0);
		load_seed(xsrs_pkg::GOLDEN_SEED);
		send_request(xsrs_pkg::OP_RAW, 32'd0, 32'd0);
	endtask

	task automatic test_float_rounding();
		logic [31:0] draws[8];
		draws = '{32'h0000_0000, 32'h0000_0001, 32'h00FF_FFFF, 32'h0100_0001,
			32'h8000_0000, 32'hFFFF_FF7F, 32'hFFFF_FF80, 32'hFFFF_FFFF};
		foreach (draws[i]) begin
			load_seed(seed_giving_draw(draws[i]));
			send_request(xsrs_pkg::OP_FLOAT, 32'd0, 32'd0);
		end
	endtask

	task automatic test_bounds();
		load_seed({$urandom, $urandom});
		send_request(xsrs_pkg::OP_BOUNDED, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(xsrs_pkg::OP_BOUNDED, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(xsrs_pkg::OP_BOUNDED, 32'd5, 32'd5);
		send_request(xsrs_pkg::OP_BOUNDED, 32'h8000_0000, 32'h8000_0000);
		send_request(xsrs_pkg::OP_BOUNDED, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_request(xsrs_pkg::OP_BOUNDED, 32'd100, -32'sd100);
		send_request(xsrs_pkg::OP_BOUNDED, 32'hFFFF_FFFF, 32'd0);
	endtask

	task automatic test_random_requests(input logic [63:0] seed, input int count,
			input bit quiet);
		logic [1:0]  op;
		logic [31:0] lo;
		logic [31:0] hi;
		int          pick;
		load_seed(seed);
		no_gaps = quiet;
		repeat (count) begin
			pick = $urandom_range(0, 9);
			op = (pick < 3) ? xsrs_pkg::OP_RAW : (pick < 7) ? xsrs_pkg::OP_BOUNDED
				: (pick < 9) ? xsrs_pkg::OP_FLOAT : OP_SPARE;
			lo = $urandom;
			hi = $urandom;
			case ($urandom_range(0, 3))
				0: begin
				end
				1: hi = lo + $urandom_range(0, 15);
				2: begin
					lo = hi - $urandom_range(0, 1000);
				end
				default: begin
					lo = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
					hi = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom;
				end
			endcase
			send_request(op, lo, hi);
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_output_stall();
		drain_replies();
		// hold the output so the block fills and stalls its input
		hold_cycles = 300;
		no_gaps = 1'b1;
		repeat (6) send_request(xsrs_pkg::OP_BOUNDED, $urandom, $urandom);
		no_gaps = 1'b0;
	endtask

	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			gap = no_gaps ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$error("result word with no request waiting: %h", m_tdata);
				failures++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tdata[31:0] !== want.raw_draw) begin
					$error("raw_draw expected %h actual %h", want.raw_draw, m_tdata[31:0]);
					failures++;
				end
				if (m_tdata[63:32] !== want.bounded_value) begin
					$error("bounded_value expected %h actual %h", want.bounded_value,
						m_tdata[63:32]);
					failures++;
				end
				if (m_tdata[95:64] !== want.float_bits) begin
					$error("float_bits expected %h actual %h", want.float_bits,
						m_tdata[95:64]);
					failures++;
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("xorshift64_star_random_source_top: mismatch");
		$finish;
	end

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_state();
		test_seed_extremes();
		test_float_rounding();
		test_bounds();
		test_random_requests(64'd0, 110, 1'b0);
		test_random_requests('1, 110, 1'b1);
		test_output_stall();
		test_random_requests(64'd1, 110, 1'b0);
		test_random_requests({$urandom, $urandom}, 110, 1'b0);
		test_random_requests(xsrs_pkg::GOLDEN_SEED, 110, 1'b0);
		drain_replies();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_replies.size() == 0) begin
			$display("xorshift64_star_random_source_top: match");
		end else begin
			$display("xorshift64_star_random_source_top: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
